// File: rtl/core/ddr3_command_state_machine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the command state machine RTL
// ----------------------------------------------------------------------------
`ifndef DDR3_COMMAND_STATE_MACHINE_ASSERT_SVH
`define DDR3_COMMAND_STATE_MACHINE_ASSERT_SVH

// Check that a condition implies a consequence at the same edge.
`define DDR3_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ddr3 command state machine: same-cycle check failed");

// Check that a condition implies a consequence at the next edge.
`define DDR3_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ddr3 command state machine: next-cycle check failed");

`endif

// File: rtl/core/ddr3_cmd_pkg.sv
// ----------------------------------------------------------------------------
// ddr3_cmd_pkg
// Types and constants for the DDR3 command state machine.
// ----------------------------------------------------------------------------
package ddr3_cmd_pkg;

	localparam int CMD_W         = 4;
	localparam int ADDR_W        = 10;
	localparam int DATA_W        = 8;
	localparam int STATE_W       = 4;
	localparam int STORE_DEPTH_D = 1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_ACT  = 4'd0,
		CMD_PRE  = 4'd1,
		CMD_PREA = 4'd2,
		CMD_RD   = 4'd3,
		CMD_WR   = 4'd4,
		CMD_REF  = 4'd5,
		CMD_RST  = 4'd6,
		CMD_PDE  = 4'd7,
		CMD_PDX  = 4'd8,
		CMD_ZQCL = 4'd9,
		CMD_SRE  = 4'd10,
		CMD_SRX  = 4'd11,
		CMD_NOP  = 4'd12
	} cmd_t;

	typedef enum logic [STATE_W-1:0] {
		ST_POWERON    = 4'd0,
		ST_RESET      = 4'd1,
		ST_INIT       = 4'd2,
		ST_ZQCAL      = 4'd3,
		ST_IDLE       = 4'd4,
		ST_SREFRESH   = 4'd5,
		ST_REFRESH    = 4'd6,
		ST_ACTIVE     = 4'd7,
		ST_PREPWRDOWN = 4'd8,
		ST_BANKACTIVE = 4'd9,
		ST_WRITE      = 4'd10,
		ST_READ       = 4'd11,
		ST_PRECHARGE  = 4'd12
	} state_t;

	typedef struct packed {
		state_t next_state;
		logic   store_wr;
		logic   store_rd;
	} ctrl_t;

endpackage

// File: rtl/core/ddr3_cmd_if.sv
// ----------------------------------------------------------------------------
// ddr3_cmd_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface ddr3_cmd_in_if;
	logic                             valid;
	logic                             ready;
	logic [ddr3_cmd_pkg::CMD_W-1:0]  command;
	logic [ddr3_cmd_pkg::ADDR_W-1:0] address;
	logic [ddr3_cmd_pkg::DATA_W-1:0] write_data;
	logic [ddr3_cmd_pkg::DATA_W-1:0] byte_mask;

	modport source (output valid, command, address, write_data, byte_mask, input ready);
	modport sink   (input valid, command, address, write_data, byte_mask, output ready);
endinterface

interface ddr3_cmd_out_if;
	logic                              valid;
	logic                              ready;
	logic [ddr3_cmd_pkg::STATE_W-1:0] device_state;
	logic                              read_valid;
	logic [ddr3_cmd_pkg::DATA_W-1:0]  read_data;

	modport source (output valid, device_state, read_valid, read_data, input ready);
	modport sink   (input valid, device_state, read_valid, read_data, output ready);
endinterface

// File: rtl/core/ddr3_command_state_machine.sv
// The result word of an accepted command word follows in the next cycle.
// Throughput: one command per cycle while rsp.ready lets the result drain; the state
// update and the single port access to the word store (read or write) share a cycle.
// Reset: arst_n returns the device state to POWERON and empties the result
// register; the word store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// ddr3_command_state_machine
// Simplified DDR3 device: command state machine with a one-port word store.
// ----------------------------------------------------------------------------
`include "ddr3_command_state_machine_assert.svh"

module ddr3_command_state_machine #(
	parameter int STORE_DEPTH = ddr3_cmd_pkg::STORE_DEPTH_D
) (
	input  logic            clk,
	input  logic            arst_n,
	ddr3_cmd_in_if.sink     cmd,
	ddr3_cmd_out_if.source  rsp
);
	import ddr3_cmd_pkg::*;

	localparam int IDX_W     = $clog2(STORE_DEPTH);
	localparam int MOD_STEPS = 7;

	// Wrap the address into the store with constant compare-subtract steps.
	function automatic logic [IDX_W-1:0] store_index(input logic [ADDR_W-1:0] a);
		int unsigned r;
		r = int'(a);
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (r >= (STORE_DEPTH << k)) r = r - (STORE_DEPTH << k);
		end
		return r[IDX_W-1:0];
	endfunction

	ctrl_t             ctrl;
	logic              accept;
	logic [IDX_W-1:0]  idx;
	logic [DATA_W-1:0] store_mem [STORE_DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic              valid_s1;
	state_t            state_s1;
	logic              rvalid_s1;
	logic [DATA_W-1:0] mask_s1;

	// Take a new word whenever the result register is empty or draining.
	assign cmd.ready = !valid_s1 || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign idx       = store_index(cmd.address);

	ddr3_cmd_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.command (cmd.command),
		.ctrl    (ctrl)
	);

	always_ff @(posedge clk) begin
		if (accept && ctrl.store_wr) begin
			store_mem[idx] <= cmd.write_data;
		end
	end

	// Hold the read word while the result stalls.
	always_ff @(posedge clk) begin
		if (accept && ctrl.store_rd) begin
			rd_data_q <= store_mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			rvalid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1  <= cmd.valid;
			rvalid_s1 <= cmd.valid && ctrl.store_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			state_s1 <= ctrl.next_state;
			// zero mask forces read_data to zero when no read completes
			mask_s1  <= ctrl.store_rd ? cmd.byte_mask : '0;
		end
	end

	assign rsp.valid        = valid_s1;
	assign rsp.device_state = state_s1;
	assign rsp.read_valid   = rvalid_s1;
	assign rsp.read_data    = rd_data_q & mask_s1;

	`DDR3_ASSERT_SAME(a_read_in_precharge, rsp.valid && rsp.read_valid,
		rsp.device_state == ST_PRECHARGE)
	`DDR3_ASSERT_SAME(a_no_read_zero_data, rsp.valid && !rsp.read_valid,
		rsp.read_data == '0)
	`DDR3_ASSERT_NEXT(a_accept_gives_result, accept, rsp.valid)
	`DDR3_ASSERT_NEXT(a_rst_forces_reset, accept && (cmd.command == CMD_RST),
		rsp.device_state == ST_RESET)

endmodule

// File: rtl/core/ddr3_cmd_fsm.sv
// ----------------------------------------------------------------------------
// ddr3_cmd_fsm
// Device state register, next-state decode and store access strobes.
// ----------------------------------------------------------------------------
module ddr3_cmd_fsm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic [ddr3_cmd_pkg::CMD_W-1:0] command,
	output ddr3_cmd_pkg::ctrl_t             ctrl
);
	import ddr3_cmd_pkg::*;

	state_t state_q;
	state_t state_d;
	cmd_t   cmd;
	logic   is_pre;

	assign cmd = cmd_t'(command);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_POWERON:    state_d = ST_RESET;
			ST_RESET:      state_d = ST_INIT;
			ST_INIT:       if (cmd == CMD_ZQCL) state_d = ST_ZQCAL;
			ST_ZQCAL:      state_d = ST_IDLE;
			ST_IDLE: begin
				if (cmd == CMD_ACT)      state_d = ST_ACTIVE;
				else if (cmd == CMD_PDE) state_d = ST_PREPWRDOWN;
				else if (cmd == CMD_SRE) state_d = ST_SREFRESH;
				else if (cmd == CMD_REF) state_d = ST_REFRESH;
			end
			ST_ACTIVE:     state_d = ST_BANKACTIVE;
			ST_PREPWRDOWN: if (cmd == CMD_PDX) state_d = ST_IDLE;
			ST_SREFRESH:   if (cmd == CMD_SRX) state_d = ST_IDLE;
			ST_REFRESH:    state_d = ST_IDLE;
			ST_BANKACTIVE: begin
				if (cmd == CMD_WR)      state_d = ST_WRITE;
				else if (cmd == CMD_RD) state_d = ST_READ;
			end
			ST_WRITE:      if (is_pre) state_d = ST_PRECHARGE;
			ST_READ:       if (is_pre) state_d = ST_PRECHARGE;
			ST_PRECHARGE:  state_d = ST_IDLE;
			default:       state_d = ST_POWERON;
		endcase
		// reset command wins from any state
		if (cmd == CMD_RST) state_d = ST_RESET;
	end

	always_comb begin
		is_pre          = (cmd == CMD_PRE) || (cmd == CMD_PREA);
		ctrl.next_state = state_d;
		ctrl.store_wr   = (state_q == ST_WRITE) && is_pre;
		ctrl.store_rd   = (state_q == ST_READ) && is_pre;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_POWERON;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

endmodule
